// ===== rtl/swr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_pkg: shared types and codes of the sliding window rate counter
// Beat formats of both channels, the command format between the front and
// the back, and the op and command codes.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int SUM_W = 35;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Op codes of the input beat.
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Command classes handed from the front to the back.
  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  kind;
    logic [63:0] byte_count;
  } in_t;

  typedef struct packed {
    logic             kind_valid;
    logic [SUM_W-1:0] count_sum;
    logic [63:0]      bytes_sum;
    logic [63:0]      grand_total;
  } out_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [2:0]  kind;
    logic        kind_valid;
    logic [63:0] byte_count;
  } cmd_t;

endpackage

// ===== rtl/swr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 42
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/swr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_front: input side of the rate counter
// Accepts input beats, classifies op and kind, and holds them in a
// two-entry queue until the back takes them.
// ----------------------------------------------------------------------------
module swr_front #(
  parameter int KINDS = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  swr_pkg::in_t in_data,
  output logic         cmd_valid,
  input  logic         cmd_ready,
  output swr_pkg::cmd_t cmd
);
  import swr_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls_cmd;
  logic       do_push, do_pop;

  always_comb begin
    cls_cmd.kind       = in_data.kind;
    cls_cmd.byte_count = in_data.byte_count;
    cls_cmd.kind_valid = (int'(in_data.kind) < KINDS);
    unique case (in_data.op)
      OP_EVENT: cls_cmd.cls = CMD_EVENT;
      OP_TICK:  cls_cmd.cls = CMD_TICK;
      default:  cls_cmd.cls = CMD_READ;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cls_cmd;
    end
  end

endmodule

// ===== rtl/swr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_back: bucket sequencer of the rate counter
// Owns the bucket RAM, clears it after reset, carries out events, ticks
// and window sums one RAM access a cycle, and holds the result beat.
// ----------------------------------------------------------------------------
module swr_back #(
  parameter int KINDS      = 7,
  parameter int WINDOW     = 5,
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  swr_pkg::cmd_t cmd,
  output logic          empty,
  input  logic          pop,
  output swr_pkg::out_t out_data
);
  import swr_pkg::*;

  localparam int SLOTS = WINDOW + 1;
  localparam int DEPTH = KINDS * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SLOTS);
  localparam int KCW   = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int EW    = COUNT_BITS + 64;
  localparam int SUMW  = ((COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W) + 1;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_EV_WR   = 3'd2;
  localparam logic [2:0] ST_TICK    = 3'd3;
  localparam logic [2:0] ST_SUM     = 3'd4;
  localparam logic [2:0] ST_SUM_END = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [SW-1:0]    cur_r, cur_nxt;
  logic [63:0]      gt_r, gt_nxt;
  logic [KCW-1:0]   kcnt_r, kcnt_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [SW-1:0]    sd_r, sd_nxt;
  logic             pend_r, pend_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic             valid_r, valid_nxt;
  logic [63:0]      nbytes_r, nbytes_nxt;
  logic [AW-1:0]    ev_addr_r, ev_addr_nxt;
  logic [SUM_W-1:0] csum_r, csum_nxt;
  logic [63:0]      bsum_r, bsum_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;

  logic [COUNT_BITS-1:0] rd_cnt;
  logic [63:0]           rd_bytes;
  logic [SUMW-1:0]       sum_wide;
  logic                  take;

  swr_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_cnt    = rd_data[EW-1:64];
  assign rd_bytes  = rd_data[63:0];
  assign sum_wide  = SUMW'(csum_r) + SUMW'(rd_cnt);
  assign cmd_ready = (state_r == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign empty     = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    gt_nxt        = gt_r;
    kcnt_nxt      = kcnt_r;
    slot_nxt      = slot_r;
    sd_nxt        = sd_r;
    pend_nxt      = 1'b0;
    kind_nxt      = kind_r;
    valid_nxt     = valid_r;
    nbytes_nxt    = nbytes_r;
    ev_addr_nxt   = ev_addr_r;
    csum_nxt      = csum_r;
    bsum_nxt      = bsum_r;
    out_valid_nxt = out_valid_r && !pop;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = clr_r;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = ev_addr_r;

    // The read issued in the previous cycle lands here during a window sum.
    if (pend_r && (sd_r != cur_r)) begin
      csum_nxt = (sum_wide > SUMW'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
      bsum_nxt = bsum_r + rd_bytes;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          kind_nxt   = cmd.kind;
          valid_nxt  = cmd.kind_valid;
          nbytes_nxt = cmd.byte_count;
          csum_nxt   = '0;
          bsum_nxt   = '0;
          slot_nxt   = '0;
          kcnt_nxt   = '0;
          ev_addr_nxt = AW'(int'(cmd.kind) * SLOTS + int'(cur_r));
          unique case (cmd.cls)
            CMD_EVENT: begin
              gt_nxt = gt_r + 64'd1;
              if (cmd.kind_valid) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(int'(cmd.kind) * SLOTS + int'(cur_r));
                state_nxt = ST_EV_WR;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            CMD_TICK: begin
              cur_nxt   = (cur_r == SW'(WINDOW)) ? '0 : cur_r + 1'b1;
              state_nxt = ST_TICK;
            end
            default: begin
              state_nxt = cmd.kind_valid ? ST_SUM : ST_DONE;
            end
          endcase
        end
      end
      ST_EV_WR: begin
        wr_en     = 1'b1;
        wr_addr   = ev_addr_r;
        wr_data   = {(&rd_cnt) ? rd_cnt : rd_cnt + 1'b1, rd_bytes + nbytes_r};
        state_nxt = ST_SUM;
      end
      ST_TICK: begin
        wr_en    = 1'b1;
        wr_addr  = AW'(int'(kcnt_r) * SLOTS + int'(cur_r));
        kcnt_nxt = kcnt_r + 1'b1;
        if (kcnt_r == KCW'(KINDS - 1)) begin
          state_nxt = valid_r ? ST_SUM : ST_DONE;
        end
      end
      ST_SUM: begin
        rd_en    = 1'b1;
        rd_addr  = AW'(int'(kind_r) * SLOTS + int'(slot_r));
        pend_nxt = 1'b1;
        sd_nxt   = slot_r;
        slot_nxt = slot_r + 1'b1;
        if (slot_r == SW'(WINDOW)) begin
          state_nxt = ST_SUM_END;
        end
      end
      ST_SUM_END: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt       = 1'b1;
          out_nxt.kind_valid  = valid_r;
          out_nxt.count_sum   = csum_r;
          out_nxt.bytes_sum   = bsum_r;
          out_nxt.grand_total = gt_r;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      gt_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      gt_r        <= gt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kcnt_r    <= kcnt_nxt;
    slot_r    <= slot_nxt;
    sd_r      <= sd_nxt;
    kind_r    <= kind_nxt;
    valid_r   <= valid_nxt;
    nbytes_r  <= nbytes_nxt;
    ev_addr_r <= ev_addr_nxt;
    csum_r    <= csum_nxt;
    bsum_r    <= bsum_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== rtl/per_kind_sliding_window_event_rate_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_kind_sliding_window_event_rate_core: per-kind sliding window counter
// Top level: input queue front, bucket sequencer back, result register.
// ----------------------------------------------------------------------------
// Each beat on the input carries an op (record event, one-second tick or
// read) and an event kind, and returns exactly one result beat holding the
// count and byte sums of that kind over the WINDOW completed one-second
// buckets, plus the running total of all events. After reset the block
// clears every address of its bucket RAM; beats can still be pushed into
// the two-entry input queue meanwhile, but nothing is processed until the
// sweep ends. All work runs through the single read port and single write
// port of the bucket RAM, one bucket a cycle unless a finished result is
// held back by a full output register, and the back works on one beat at
// a time. Results wait in an output register while the next beat is
// already being worked on.
//
// The window sum walks every slot of the kind's ring and skips the current
// slot, since that bucket is still being filled. Bucket counts saturate at
// all ones of COUNT_BITS, the reported count sum saturates at its 35-bit
// field, and byte totals wrap modulo 2^64.
module per_kind_sliding_window_event_rate_core #(
  parameter int KINDS      = 7,
  parameter int WINDOW     = 5,
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  swr_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output swr_pkg::out_t out_data
);
  import swr_pkg::*;

  // Classified beats waiting for the sequencer.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // The front only decodes and queues; it never looks at bucket state, so
  // it keeps taking beats while the back is busy or the result waits, until its queue is full.
  swr_front #(
    .KINDS(KINDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // The back owns the ring position, the event total and the bucket RAM,
  // and it presents one finished result beat at a time.
  swr_back #(
    .KINDS     (KINDS),
    .WINDOW    (WINDOW),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ===== rtl/swr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_checker: port-level assertions for the rate counter
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module swr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          empty,
  input logic          pop,
  input swr_pkg::out_t out_data
);
  import swr_pkg::*;

  // A waiting result beat must not change or vanish until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result beat changed while stalled");

  // Reset drops any pending result.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result shown right after reset");

  // An invalid kind reports empty sums.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.kind_valid) |->
      (out_data.count_sum == '0 && out_data.bytes_sum == '0))
    else $error("invalid kind reported nonzero sums");

  // Bytes only land in a bucket together with a counted event.
  a_bytes_need_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.bytes_sum != '0) |-> (out_data.count_sum != '0))
    else $error("byte sum without any counted event");

endmodule

bind per_kind_sliding_window_event_rate_core swr_checker u_swr_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);
